/* sv/spq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Word types, request and status codes, and the per-cycle cell command.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH_DEF     = 64;
	localparam int PRIO_BITS_DEF = 8;
	localparam int CAP_W         = 7;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic       req_type;
		logic [7:0] item_prio;
		logic [7:0] item_char;
	} req_t;

	typedef struct packed {
		logic [7:0]       out_prio;
		logic [7:0]       out_char;
		logic [1:0]       status;
		logic [CAP_W-1:0] entry_count;
		logic             is_empty;
		logic             is_full;
	} res_t;

	typedef struct packed {
		logic ins;
		logic rem;
	} cell_cmd_t;

endpackage

/* sv/sorted_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue
// Row of shifting cells keeping entries ordered, largest priority at cell 0.
// ----------------------------------------------------------------------------
// A request word is taken on start while busy is low; busy never rises, so
// one word can be taken every clock cycle. Each request gives one result
// word on result, marked by done, in the cycle after it is taken: the
// removed entry (zero on insert or refusal), a status code, and the count,
// empty and full flags after the request. Every cell compares and shifts in
// parallel with its neighbors on inserts and removes. The receiver cannot
// stall; a result word is shown once. Writing cfg_wdata with cfg_we sets
// the capacity (zero becomes one, values above DEPTH become DEPTH) and
// empties the queue. Reset empties the queue and sets the capacity to 64
// or DEPTH, whichever is smaller. Cell contents are not cleared; only
// entries below the count are ever read.
// ----------------------------------------------------------------------------
module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int PRIO_BITS = PRIO_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  req_t             req,
	output logic             done,
	output res_t             result,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int ENT_W = PRIO_BITS + 8;
	localparam logic [CNT_W-1:0] CAP_RST = (DEPTH < 64) ? CNT_W'(DEPTH) : CNT_W'(64);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] cap_q;
	logic [CNT_W-1:0] count_nx;
	logic [CNT_W-1:0] cap_nx;
	logic [CMP_W-1:0] cfg_ext;
	logic             done_q;
	res_t             result_q;
	res_t             result_nx;
	logic             accept;
	logic             ins_ok;
	logic             rem_ok;
	cell_cmd_t        cmd;
	logic [ENT_W-1:0] new_ent;
	logic [ENT_W-1:0] ent   [DEPTH];
	logic             sh    [DEPTH];

	assign busy    = 1'b0;
	assign done    = done_q;
	assign result  = result_q;
	assign accept  = start && !busy;
	assign ins_ok  = accept && (req.req_type == REQ_INSERT) && (count_q < cap_q);
	assign rem_ok  = accept && (req.req_type == REQ_REMOVE) && (count_q != '0);
	assign cmd.ins = ins_ok;
	assign cmd.rem = rem_ok;
	assign new_ent = {PRIO_BITS'(req.item_prio), req.item_char};

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic [ENT_W-1:0] l_ent;
			logic [ENT_W-1:0] r_ent;
			logic             l_sh;
			if (i == 0) begin : g_first
				assign l_ent = new_ent;
				assign l_sh  = 1'b0;
			end else begin : g_mid
				assign l_ent = ent[i-1];
				assign l_sh  = sh[i-1];
			end
			if (i == DEPTH - 1) begin : g_last
				assign r_ent = ent[i];
			end else begin : g_inner
				assign r_ent = ent[i+1];
			end
			spq_cell #(
				.PRIO_BITS(PRIO_BITS)
			) u_cell (
				.clk      (clk),
				.cmd      (cmd),
				.occ      (count_q > CNT_W'(i)),
				.at_end   (count_q == CNT_W'(i)),
				.new_ent  (new_ent),
				.left_ent (l_ent),
				.left_sh  (l_sh),
				.right_ent(r_ent),
				.ent      (ent[i]),
				.sh       (sh[i])
			);
		end
	endgenerate

	always_comb begin
		cfg_ext = CMP_W'(cfg_wdata);
		if (cfg_ext == '0) begin
			cap_nx = CNT_W'(1);
		end else if (cfg_ext > CMP_W'(DEPTH)) begin
			cap_nx = CNT_W'(DEPTH);
		end else begin
			cap_nx = CNT_W'(cfg_ext);
		end

		count_nx = count_q;
		if (ins_ok) begin
			count_nx = count_q + CNT_W'(1);
		end else if (rem_ok) begin
			count_nx = count_q - CNT_W'(1);
		end

		result_nx             = '0;
		result_nx.entry_count = CAP_W'(count_nx);
		result_nx.is_empty    = (count_nx == '0);
		result_nx.is_full     = (count_nx == cap_q);
		if (req.req_type == REQ_INSERT) begin
			if (!ins_ok) begin
				result_nx.status = STAT_FULL;
			end
		end else if (rem_ok) begin
			result_nx.out_prio = 8'(ent[0][ENT_W-1:8]);
			result_nx.out_char = ent[0][7:0];
		end else begin
			result_nx.status = STAT_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= CAP_RST;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (cfg_we) begin
				cap_q   <= cap_nx;
				count_q <= '0;
			end else begin
				count_q <= count_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_nx;
		end
	end

endmodule

/* sv/spq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry, compares it with an incoming word and shifts with its
// neighbors on insert and remove.
// ----------------------------------------------------------------------------
module spq_cell
	import spq_pkg::*;
#(
	parameter int PRIO_BITS = PRIO_BITS_DEF
) (
	input  logic                 clk,
	input  cell_cmd_t            cmd,
	input  logic                 occ,
	input  logic                 at_end,
	input  logic [PRIO_BITS+7:0] new_ent,
	input  logic [PRIO_BITS+7:0] left_ent,
	input  logic                 left_sh,
	input  logic [PRIO_BITS+7:0] right_ent,
	output logic [PRIO_BITS+7:0] ent,
	output logic                 sh
);

	logic [PRIO_BITS+7:0] ent_q;

	assign ent = ent_q;
	assign sh  = occ && (ent_q[PRIO_BITS+7:8] <= new_ent[PRIO_BITS+7:8]);

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (left_sh) begin
				ent_q <= left_ent;
			end else if (sh || at_end) begin
				ent_q <= new_ent;
			end
		end else if (cmd.rem) begin
			ent_q <= right_ent;
		end
	end

endmodule
